FILE: rtl/core/rrtu_pkg.sv
// Shared types and constants for the route table update block.
// Used by the top level and by its port checker; depends on nothing else.
`timescale 1ns / 1ps

package rrtu_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int KEY_W    = 32;
	localparam int METRIC_W = 5;
	localparam int HOP_W    = 8;
	localparam int SLOT_W   = 6;
	localparam int ACT_W    = 2;
	localparam int STAT_W   = 2;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 3;

	localparam logic [METRIC_W-1:0] METRIC_INF = 5'd16;

	typedef enum logic [ACT_W-1:0] {
		ACT_INSTALL = 2'd0,
		ACT_ADVERT  = 2'd1,
		ACT_READ    = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_UNCHANGED = 2'd0,
		STAT_INSERTED  = 2'd1,
		STAT_REPLACED  = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [METRIC_W-1:0] metric;
		logic [HOP_W-1:0]    hop;
	} entry_t;

endpackage

FILE: rtl/core/rip_route_table_update.sv
// Install and advert requests scan the table one slot per cycle through the registered
// entry memory and stop early on a key hit; a read request reads its slot, and an unused
// action goes straight to the result.
// One request is in flight at a time; the next can be taken in the cycle after its result is loaded,
// and the loading of a result waits while the output is stalled.
// Reset (arst_n low) clears all valid bits and the control state; the memory is not cleared.
`timescale 1ns / 1ps

module rip_route_table_update (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// network[31:0], metric_in[36:32], router_id[44:37], slot[50:45], zero fill above
	input  logic [rrtu_pkg::IN_DATA_W-1:0]   s_tdata,
	// action[1:0]
	input  logic [rrtu_pkg::ACT_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// slot_out[5:0], network_out[37:6], metric_out[42:38], next_hop_out[50:43], zero fill above
	output logic [rrtu_pkg::OUT_DATA_W-1:0]  m_tdata,
	// entry_valid[0], status[2:1]
	output logic [rrtu_pkg::OUT_USER_W-1:0]  m_tuser
);
	import rrtu_pkg::*;

	// Input field unpacking.
	logic [KEY_W-1:0]    in_network;
	logic [METRIC_W-1:0] in_metric;
	logic [HOP_W-1:0]    in_router;
	logic [SLOT_W-1:0]   in_slot;
	action_t             in_action;

	assign in_network = s_tdata[31:0];
	assign in_metric  = s_tdata[36:32];
	assign in_router  = s_tdata[44:37];
	assign in_slot    = s_tdata[50:45];
	assign in_action  = action_t'(s_tuser);

	state_t state_q, state_d;

	// Latched request.
	action_t             action_q;
	logic [KEY_W-1:0]    key_q;
	logic [METRIC_W-1:0] metric_q;
	logic [HOP_W-1:0]    rid_q;
	logic [SLOT_W-1:0]   slot_q;

	// Scan control and compare stage.
	logic [IDX_W-1:0]    scan_q;
	logic                scan_done_q;
	logic                cmp_vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	entry_t              rdata_s1;

	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [METRIC_W-1:0] hit_metric_q;
	logic [HOP_W-1:0]    hit_hop_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;

	logic [TABLE_DEPTH-1:0] valid_q;
	entry_t                 mem [TABLE_DEPTH];

	// Output register.
	logic                out_vld_q;
	logic [SLOT_W-1:0]   out_slot_q;
	logic [KEY_W-1:0]    out_key_q;
	logic [METRIC_W-1:0] out_metric_q;
	logic [HOP_W-1:0]    out_hop_q;
	logic                out_valid_bit_q;
	status_t             out_status_q;

	logic                accept;
	logic                match;
	logic                scan_last;
	logic                out_load;
	logic [METRIC_W-1:0] new_metric;
	logic [IDX_W-1:0]    rd_idx;
	logic                slot_in_range;

	// Memory access and result, decided per state.
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [SLOT_W-1:0]   res_slot;
	logic [KEY_W-1:0]    res_key;
	logic [METRIC_W-1:0] res_metric;
	logic [HOP_W-1:0]    res_hop;
	logic                res_valid;
	status_t             res_status;
	logic                take;

	assign accept    = s_tvalid && s_tready;
	assign match     = cmp_vld_s1 && valid_q[idx_s1] && (rdata_s1.key == key_q);
	assign scan_last = cmp_vld_s1 && (idx_s1 == IDX_W'(TABLE_DEPTH - 1));
	assign out_load  = (state_q == S_FINISH) && (!out_vld_q || m_tready);
	assign rd_idx    = IDX_W'(slot_q);
	assign slot_in_range = (32'(slot_q) < TABLE_DEPTH);

	// Install clamps at infinity; an advert adds one hop and saturates there.
	always_comb begin
		if (in_action == ACT_INSTALL) begin
			new_metric = (in_metric > METRIC_INF) ? METRIC_INF : in_metric;
		end else begin
			new_metric = (in_metric >= METRIC_INF) ? METRIC_INF : in_metric + 5'd1;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_action == ACT_READ) begin
						state_d = S_READ;
					end else if (in_action == ACT_NONE) begin
						state_d = S_FINISH;
					end else begin
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (match || scan_last) begin
					state_d = S_FINISH;
				end
			end
			S_READ: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs of the state machine: memory access and the result.
	always_comb begin
		s_tready   = (state_q == S_IDLE);
		rd_en      = 1'b0;
		rd_addr    = scan_q;
		wr_en      = 1'b0;
		wr_addr    = hit_idx_q;
		res_slot   = '0;
		res_key    = '0;
		res_metric = '0;
		res_hop    = '0;
		res_valid  = 1'b0;
		res_status = STAT_UNCHANGED;
		take       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_SCAN: begin
				rd_en   = !scan_done_q;
				rd_addr = scan_q;
			end
			S_READ: begin
				rd_en   = 1'b1;
				rd_addr = rd_idx;
			end
			S_FINISH: begin
				unique case (action_q) inside
					ACT_READ: begin
						res_slot = slot_q;
						if (slot_in_range && valid_q[rd_idx]) begin
							res_key    = rdata_s1.key;
							res_metric = rdata_s1.metric;
							res_hop    = rdata_s1.hop;
							res_valid  = 1'b1;
						end
					end
					ACT_INSTALL, ACT_ADVERT: begin
						if (hit_q) begin
							take = (action_q == ACT_INSTALL) || (hit_hop_q == rid_q)
								|| (metric_q < hit_metric_q);
							res_slot  = SLOT_W'(hit_idx_q);
							res_key   = key_q;
							res_valid = 1'b1;
							if (take) begin
								wr_en      = out_load;
								wr_addr    = hit_idx_q;
								res_metric = metric_q;
								res_hop    = rid_q;
								res_status = STAT_REPLACED;
							end else begin
								res_metric = hit_metric_q;
								res_hop    = hit_hop_q;
							end
						end else if (free_q) begin
							wr_en      = out_load;
							wr_addr    = free_idx_q;
							res_slot   = SLOT_W'(free_idx_q);
							res_key    = key_q;
							res_metric = metric_q;
							res_hop    = rid_q;
							res_valid  = 1'b1;
							res_status = STAT_INSERTED;
						end else begin
							res_key    = key_q;
							res_metric = metric_q;
							res_hop    = rid_q;
							res_status = STAT_FULL;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	// Entry memory: one read port with registered data, one write port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= '{key: key_q, metric: metric_q, hop: rid_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			scan_q      <= '0;
			scan_done_q <= 1'b0;
			cmp_vld_s1  <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end

			if (accept) begin
				scan_q      <= '0;
				scan_done_q <= 1'b0;
				cmp_vld_s1  <= 1'b0;
				hit_q       <= 1'b0;
				free_q      <= 1'b0;
			end else if (state_q == S_SCAN) begin
				cmp_vld_s1 <= !scan_done_q && !match;
				if (scan_q == IDX_W'(TABLE_DEPTH - 1)) begin
					scan_done_q <= 1'b1;
				end else begin
					scan_q <= scan_q + 1'b1;
				end
				if (match) begin
					hit_q <= 1'b1;
				end
				// Keep only the lowest empty slot seen.
				if (cmp_vld_s1 && !valid_q[idx_s1] && !free_q) begin
					free_q <= 1'b1;
				end
			end else begin
				cmp_vld_s1 <= 1'b0;
			end

			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers without reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= in_action;
			key_q    <= in_network;
			metric_q <= new_metric;
			rid_q    <= in_router;
			slot_q   <= in_slot;
		end
		idx_s1 <= scan_q;
		if (state_q == S_SCAN && match) begin
			hit_idx_q    <= idx_s1;
			hit_metric_q <= rdata_s1.metric;
			hit_hop_q    <= rdata_s1.hop;
		end
		if (state_q == S_SCAN && cmp_vld_s1 && !valid_q[idx_s1] && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (out_load) begin
			out_slot_q      <= res_slot;
			out_key_q       <= res_key;
			out_metric_q    <= res_metric;
			out_hop_q       <= res_hop;
			out_valid_bit_q <= res_valid;
			out_status_q    <= res_status;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'd0, out_hop_q, out_metric_q, out_key_q, out_slot_q};
	assign m_tuser  = {out_status_q, out_valid_bit_q};

endmodule

FILE: rtl/core/rrtu_checker.sv
// Port-level checker for the route table update block, bound to its top level.
// Depends on rrtu_pkg for the status codes and field widths.
`timescale 1ns / 1ps

module rrtu_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [rrtu_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [rrtu_pkg::OUT_USER_W-1:0]  m_tuser
);
	import rrtu_pkg::*;

	logic                entry_valid;
	logic [STAT_W-1:0]   status;
	logic [SLOT_W-1:0]   slot_out;
	logic [KEY_W-1:0]    network_out;
	logic [METRIC_W-1:0] metric_out;
	logic [HOP_W-1:0]    next_hop_out;

	assign entry_valid  = m_tuser[0];
	assign status       = m_tuser[2:1];
	assign slot_out     = m_tdata[5:0];
	assign network_out  = m_tdata[37:6];
	assign metric_out   = m_tdata[42:38];
	assign next_hop_out = m_tdata[50:43];

	// A stalled result must hold.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A dropped insert reports slot zero and no route.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status == STAT_FULL) |-> !entry_valid && (slot_out == '0))
		else $error("table full result malformed");

	// Inserted or replaced routes are valid and hold a legal hop count.
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((status == STAT_INSERTED) || (status == STAT_REPLACED))
		|-> entry_valid && (metric_out <= METRIC_INF))
		else $error("written route malformed");

	// A result with no route and no change, such as an empty read, shows all-zero route fields.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status == STAT_UNCHANGED) && !entry_valid
		|-> (network_out == '0) && (metric_out == '0) && (next_hop_out == '0))
		else $error("empty slot result not zero");

endmodule

bind rip_route_table_update rrtu_checker u_rrtu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: dv/rrtu_route_checker.sv
// Route table checker: watches both stream ports of the route table update block,
// keeps its own copy of the table, and compares every result with the predicted entry.
// Depends on rrtu_pkg for widths, actions and status codes.
`timescale 1ns / 1ps

module rrtu_route_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [rrtu_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [rrtu_pkg::ACT_W-1:0]      s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [rrtu_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [rrtu_pkg::OUT_USER_W-1:0] m_tuser,
	output int                              failures,
	output int                              pending,
	output int                              routes_held
);
	import rrtu_pkg::*;

	typedef struct {
		logic [SLOT_W-1:0]   slot;
		logic [KEY_W-1:0]    network;
		logic [METRIC_W-1:0] metric;
		logic [HOP_W-1:0]    next_hop;
		logic                valid;
		status_t             status;
	} route_result_t;

	logic [KEY_W-1:0]    route_net  [TABLE_DEPTH];
	logic [METRIC_W-1:0] route_cost [TABLE_DEPTH];
	logic [HOP_W-1:0]    route_via  [TABLE_DEPTH];
	bit                  route_live [TABLE_DEPTH];

	route_result_t expected_routes[$];
	int            fail_cnt;
	int            live_cnt;

	function automatic route_result_t make_result(logic [SLOT_W-1:0] slot,
			logic [KEY_W-1:0] network, logic [METRIC_W-1:0] metric,
			logic [HOP_W-1:0] next_hop, logic valid, status_t status);
		route_result_t r;
		r.slot     = slot;
		r.network  = network;
		r.metric   = metric;
		r.next_hop = next_hop;
		r.valid    = valid;
		r.status   = status;
		return r;
	endfunction

	function automatic route_result_t slot_view(int idx, status_t status);
		return make_result(SLOT_W'(idx), route_net[idx], route_cost[idx], route_via[idx],
			route_live[idx], status);
	endfunction

	function automatic void store_route(int idx, logic [KEY_W-1:0] network,
			logic [METRIC_W-1:0] cost, logic [HOP_W-1:0] via);
		if (!route_live[idx])
			live_cnt++;
		route_net[idx]  = network;
		route_cost[idx] = cost;
		route_via[idx]  = via;
		route_live[idx] = 1'b1;
	endfunction

	// Applies one request to the local table and returns the entry the block should show.
	function automatic route_result_t apply_request(action_t act, logic [KEY_W-1:0] network,
			logic [METRIC_W-1:0] metric_in, logic [HOP_W-1:0] router_id,
			logic [SLOT_W-1:0] slot);
		logic [METRIC_W:0]   grown;
		logic [METRIC_W-1:0] cost;
		int                  hit;
		int                  free_idx;
		hit      = -1;
		free_idx = -1;
		if (act == ACT_READ) begin
			if (slot < TABLE_DEPTH && route_live[slot])
				return slot_view(int'(slot), STAT_UNCHANGED);
			return make_result(slot, '0, '0, '0, 1'b0, STAT_UNCHANGED);
		end
		if (act == ACT_NONE)
			return make_result('0, '0, '0, '0, 1'b0, STAT_UNCHANGED);

		if (act == ACT_INSTALL) begin
			cost = (metric_in > METRIC_INF) ? METRIC_INF : metric_in;
		end else begin
			grown = {1'b0, metric_in} + 1'b1;
			cost  = (grown > METRIC_INF) ? METRIC_INF : grown[METRIC_W-1:0];
		end

		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (hit < 0 && route_live[i] && route_net[i] == network)
				hit = i;
			if (free_idx < 0 && !route_live[i])
				free_idx = i;
		end

		if (hit >= 0) begin
			// An advert wins if it comes from the current next hop or is strictly better.
			if (act == ACT_INSTALL || route_via[hit] == router_id || cost < route_cost[hit]) begin
				store_route(hit, network, cost, router_id);
				return slot_view(hit, STAT_REPLACED);
			end
			return slot_view(hit, STAT_UNCHANGED);
		end
		if (free_idx >= 0) begin
			store_route(free_idx, network, cost, router_id);
			return slot_view(free_idx, STAT_INSERTED);
		end
		return make_result('0, network, cost, router_id, 1'b0, STAT_FULL);
	endfunction

	function automatic void match_field(string name, logic [KEY_W-1:0] want,
			logic [KEY_W-1:0] got);
		if (got !== want) begin
			fail_cnt++;
			$display("%0t: route result %s mismatch: expected %0h, actual %0h",
				$time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		route_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_DEPTH; i++)
				route_live[i] = 1'b0;
			expected_routes.delete();
			live_cnt    = 0;
			fail_cnt    = 0;
			failures    <= 0;
			pending     <= 0;
			routes_held <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_routes.size() == 0) begin
					fail_cnt++;
					$display("%0t: route result with no request waiting: actual data %0h user %0h",
						$time, m_tdata, m_tuser);
				end else begin
					want = expected_routes.pop_front();
					match_field("slot", KEY_W'(want.slot), KEY_W'(m_tdata[5:0]));
					match_field("network", want.network, m_tdata[37:6]);
					match_field("metric", KEY_W'(want.metric), KEY_W'(m_tdata[42:38]));
					match_field("next_hop", KEY_W'(want.next_hop), KEY_W'(m_tdata[50:43]));
					match_field("entry_valid", KEY_W'(want.valid), KEY_W'(m_tuser[0]));
					match_field("status", KEY_W'(want.status), KEY_W'(m_tuser[2:1]));
				end
			end
			if (s_tvalid && s_tready)
				expected_routes.push_back(apply_request(action_t'(s_tuser), s_tdata[31:0],
					s_tdata[36:32], s_tdata[44:37], s_tdata[50:45]));
			failures    <= fail_cnt;
			pending     <= expected_routes.size();
			routes_held <= live_cnt;
		end
	end

endmodule

FILE: dv/tb_rip_route_table_update.sv
// Top of the route table update testbench: clock, reset, request stimulus and the sink side.
// Needs rrtu_pkg, the rip_route_table_update block and the rrtu_route_checker module.
`timescale 1ns / 1ps

module tb_rip_route_table_update;
	import rrtu_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [ACT_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	int                    failures;
	int                    pending;
	int                    routes_held;

	logic [KEY_W-1:0] key_pool [96];
	int               burst_left;

	rip_route_table_update dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	rrtu_route_checker route_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.failures    (failures),
		.pending     (pending),
		.routes_held (routes_held)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("tb_rip_route_table_update: done, errors");
		$finish;
	end

	// Holds one request until it is taken, then either keeps the burst going or idles.
	task automatic offer(action_t act, logic [KEY_W-1:0] network, logic [METRIC_W-1:0] metric_in,
			logic [HOP_W-1:0] router_id, logic [SLOT_W-1:0] slot);
		s_tuser  <= act;
		s_tdata  <= {{(IN_DATA_W - 51){1'b0}}, slot, router_id, metric_in, network};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(11);
			if ($urandom_range(3) != 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(25, 1)) @(posedge clk);
			end
		end
	endtask

	initial begin : sink
		int  cycles;
		int  mode;
		int  run;
		bit  held_off;
		cycles   = 0;
		held_off = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			mode = $urandom_range(3);
			run  = $urandom_range(40, 1);
			repeat (run) begin
				// One long hold-off lets the block fill up and push back on its input.
				if (!held_off && cycles >= 3000) begin
					m_tready <= 1'b0;
					repeat (600) @(posedge clk);
					cycles  += 600;
					held_off = 1'b1;
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(1));
					2: m_tready <= 1'b0;
					default: m_tready <= ($urandom_range(3) != 0);
				endcase
				@(posedge clk);
				cycles++;
			end
		end
	end

	initial begin : stimulus
		action_t             act;
		logic [KEY_W-1:0]    network;
		logic [METRIC_W-1:0] metric_in;
		logic [HOP_W-1:0]    router_id;
		logic [SLOT_W-1:0]   slot;
		int                  pick;
		arst_n     <= 1'b0;
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= ACT_INSTALL;
		burst_left = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 96; i++)
			key_pool[i] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every action and the corner cases of the update rule.
		offer(ACT_INSTALL, 32'h0000_0000, 5'd0, 8'h00, 6'd0);
		offer(ACT_INSTALL, 32'hFFFF_FFFF, 5'd31, 8'hFF, 6'd63);
		offer(ACT_READ, '0, '0, '0, 6'd0);
		offer(ACT_READ, '1, '1, '1, 6'd1);
		offer(ACT_ADVERT, 32'h0000_0000, 5'd15, 8'h01, 6'd0);
		offer(ACT_ADVERT, 32'h0000_0000, 5'd31, 8'h00, 6'd0);
		offer(ACT_ADVERT, 32'h0000_0000, 5'd2, 8'h05, 6'd0);
		offer(ACT_ADVERT, 32'h0000_0000, 5'd2, 8'h05, 6'd0);
		offer(ACT_ADVERT, 32'hA5A5_5A5A, 5'd16, 8'hAA, 6'd0);
		offer(ACT_ADVERT, 32'h1234_5678, 5'd0, 8'h55, 6'd0);
		offer(ACT_INSTALL, 32'hFFFF_FFFF, 5'd7, 8'h03, 6'd0);
		offer(ACT_NONE, $urandom, 5'($urandom), 8'($urandom), 6'($urandom));
		offer(ACT_ADVERT, 32'hFFFF_FFFF, 5'd6, 8'h09, 6'd0);
		offer(ACT_ADVERT, 32'hFFFF_FFFF, 5'd5, 8'h09, 6'd0);
		offer(ACT_INSTALL, 32'h1234_5678, 5'd17, 8'h55, 6'd0);
		offer(ACT_READ, '0, '0, '0, 6'd3);
		offer(ACT_READ, '0, '0, '0, 6'd2);

		// Random: keys mostly from a small pool so lookups hit, the table fills and
		// later inserts are dropped; next hops mostly from a few neighbors.
		for (int n = 0; n < 640; n++) begin
			pick      = $urandom_range(99);
			network   = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(95)];
			metric_in = ($urandom_range(7) == 0) ? 5'($urandom_range(31))
				: 5'($urandom_range(16));
			router_id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(4, 1));
			slot      = 6'($urandom);
			if (pick < 40)
				act = ACT_ADVERT;
			else if (pick < 70)
				act = ACT_INSTALL;
			else if (pick < 95)
				act = (routes_held > 0) ? ACT_READ : ACT_INSTALL;
			else
				act = ACT_NONE;
			// Reads mostly go to slots that hold a route; the rest may land on empty slots.
			if (act == ACT_READ && $urandom_range(3) != 0)
				slot = 6'($urandom_range(routes_held - 1));
			offer(act, network, metric_in, router_id, slot);
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TABLE_DEPTH + 8) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("tb_rip_route_table_update: done, clean");
		else
			$display("tb_rip_route_table_update: done, errors");
		$finish;
	end

endmodule
